// ===== design/pmq_pkg.sv =====
package pmq_pkg;

  // Default sizes of the shared slot memory and the queue table
  localparam int TotalSlotsDef = 32;
  localparam int MaxQueuesDef  = 8;

  // Fixed field widths
  localparam int CfgW   = 4;
  localparam int QIdxW  = 3;
  localparam int DataW  = 32;
  localparam int StatW  = 2;
  localparam int FuncW  = 1;

  // Operation codes
  typedef enum logic [FuncW-1:0] {
    FUNC_INSERT = 1'b0,
    FUNC_DELETE = 1'b1
  } pmq_func_e;

  // Result status codes
  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BADQ  = 2'd3
  } pmq_status_e;

  // Control sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PTR,
    ST_SLOT
  } pmq_state_e;

endpackage

// ===== design/pmq_if.sv =====
// Operation request channel
interface pmq_in_if;
  logic                              valid;
  logic                              ready;
  logic [pmq_pkg::FuncW-1:0]         func;
  logic [pmq_pkg::QIdxW-1:0]         queue_index;
  logic signed [pmq_pkg::DataW-1:0]  write_data;

  modport source (output valid, func, queue_index, write_data, input ready);
  modport sink   (input valid, func, queue_index, write_data, output ready);
endinterface

// Operation result channel
interface pmq_out_if;
  logic                              valid;
  logic                              ready;
  logic [pmq_pkg::StatW-1:0]         status;
  logic signed [pmq_pkg::DataW-1:0]  read_data;

  modport source (output valid, status, read_data, input ready);
  modport sink   (input valid, status, read_data, output ready);
endinterface

// Queue count register write channel
interface pmq_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [pmq_pkg::CfgW-1:0]   queue_count;

  modport source (output valid, queue_count, input ready);
  modport sink   (input valid, queue_count, output ready);
endinterface

// ===== design/pmq_ptr_mem.sv =====
module pmq_ptr_mem #(
  parameter int TOTAL_SLOTS = pmq_pkg::TotalSlotsDef,
  parameter int MAX_QUEUES  = pmq_pkg::MaxQueuesDef,
  localparam int OffW  = $clog2(TOTAL_SLOTS + 1),
  localparam int AddrW = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clear_i,
  input  logic              rd_en_i,
  input  logic [AddrW-1:0]  rd_addr_i,
  output logic [2*OffW-1:0] rd_data_o,
  input  logic              wr_en_i,
  input  logic [AddrW-1:0]  wr_addr_i,
  input  logic [2*OffW-1:0] wr_data_i
);

  // Front/rear pointer pair per queue; an entry without its valid bit reads as zero
  logic [2*OffW-1:0]     mem [MAX_QUEUES];
  logic [MAX_QUEUES-1:0] vld_q;
  logic [2*OffW-1:0]     rd_data_q;
  logic                  rd_vld_q;

  // Write the pointer pair
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Track written entries; drop them all on clear
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear_i) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // Registered read; hold data until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_en_i) begin
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== design/pmq_slot_mem.sv =====
module pmq_slot_mem #(
  parameter int TOTAL_SLOTS = pmq_pkg::TotalSlotsDef,
  localparam int AddrW = $clog2(TOTAL_SLOTS)
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [pmq_pkg::DataW-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [pmq_pkg::DataW-1:0] rd_data_o
);

  logic [pmq_pkg::DataW-1:0] mem [TOTAL_SLOTS];
  logic [pmq_pkg::DataW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; hold data between reads
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== design/partitioned_multi_queue.sv =====
// Several linear queues share one slot memory of TOTAL_SLOTS words, split into queue_count
// equal partitions of floor(TOTAL_SLOTS / queue_count) slots (leftover slots stay unused).
// Writing queue_count (0 is taken as 1, values above MAX_QUEUES saturate) empties every
// queue; write it only while no operation is in flight. Freed slots are not reused until
// that happens. One operation is in work at a time: an insert, a failed operation or a bad
// queue index is answered from the pointer read alone, while a successful delete goes
// on through the registered read of the pointer memory and then that of the slot memory.
// A result waiting in the output register does not block the next transfer in,
// but a new result waits until the previous one is taken.
module partitioned_multi_queue #(
  parameter int TOTAL_SLOTS = pmq_pkg::TotalSlotsDef,
  parameter int MAX_QUEUES  = pmq_pkg::MaxQueuesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  pmq_cfg_if.sink       cfg_i,
  pmq_in_if.sink        in_i,
  pmq_out_if.source     out_o
);

  localparam int OffW     = $clog2(TOTAL_SLOTS + 1);
  localparam int SlotAW   = $clog2(TOTAL_SLOTS);
  localparam int PtrAW    = (MAX_QUEUES > 1) ? $clog2(MAX_QUEUES) : 1;
  localparam int CntW     = $clog2(MAX_QUEUES + 1);
  localparam int CfgDepth = 2 ** pmq_pkg::CfgW;
  localparam int MulW     = pmq_pkg::QIdxW + OffW;

  // Count and partition size for every raw register value
  logic [CntW-1:0] cnt_tab  [CfgDepth];
  logic [OffW-1:0] size_tab [CfgDepth];

  for (genvar gi = 0; gi < CfgDepth; gi++) begin : g_tab
    localparam int Cnt = (gi < 1) ? 1 : ((gi > MAX_QUEUES) ? MAX_QUEUES : gi);
    localparam int Sz  = TOTAL_SLOTS / Cnt;
    assign cnt_tab[gi]  = CntW'(Cnt);
    assign size_tab[gi] = OffW'(Sz);
  end

  logic [CntW-1:0] queue_count_q;
  logic [OffW-1:0] size_q;
  logic            cfg_wr;

  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.valid;

  // Update queue count and partition size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_count_q <= CntW'(1);
      size_q        <= OffW'(TOTAL_SLOTS);
    end else if (cfg_wr) begin
      queue_count_q <= cnt_tab[cfg_i.queue_count];
      size_q        <= size_tab[cfg_i.queue_count];
    end
  end

  pmq_pkg::pmq_state_e state_q, state_d;

  // Operation registers captured at the input transfer
  pmq_pkg::pmq_func_e         func_q;
  logic [pmq_pkg::QIdxW-1:0]  qidx_q;
  logic [pmq_pkg::DataW-1:0]  wdata_q;
  logic                       badq_q;
  logic [SlotAW-1:0]          base_q;

  logic                       in_xfer;
  logic                       in_badq;
  logic [MulW-1:0]            base_full;

  assign in_xfer   = in_i.valid && in_i.ready;
  assign in_badq   = int'(in_i.queue_index) >= int'(queue_count_q);
  assign base_full = MulW'(in_i.queue_index) * MulW'(size_q);

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q  <= pmq_pkg::pmq_func_e'(in_i.func);
      qidx_q  <= in_i.queue_index;
      wdata_q <= in_i.write_data;
      badq_q  <= in_badq;
      base_q  <= SlotAW'(base_full);
    end
  end

  // Pointer memory
  logic              ptr_rd_en;
  logic              ptr_wr_en;
  logic [2*OffW-1:0] ptr_rd_data;
  logic [2*OffW-1:0] ptr_wr_data;
  logic [OffW-1:0]   front;
  logic [OffW-1:0]   rear;

  pmq_ptr_mem #(
    .TOTAL_SLOTS (TOTAL_SLOTS),
    .MAX_QUEUES  (MAX_QUEUES)
  ) u_ptr_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_wr),
    .rd_en_i   (ptr_rd_en),
    .rd_addr_i (PtrAW'(in_i.queue_index)),
    .rd_data_o (ptr_rd_data),
    .wr_en_i   (ptr_wr_en),
    .wr_addr_i (PtrAW'(qidx_q)),
    .wr_data_i (ptr_wr_data)
  );

  assign front = ptr_rd_data[2*OffW-1:OffW];
  assign rear  = ptr_rd_data[OffW-1:0];

  // Slot memory
  logic                      slot_wr_en;
  logic                      slot_rd_en;
  logic [SlotAW-1:0]         slot_wr_addr;
  logic [SlotAW-1:0]         slot_rd_addr;
  logic [pmq_pkg::DataW-1:0] slot_rd_data;

  assign slot_wr_addr = SlotAW'(base_q + SlotAW'(rear));
  assign slot_rd_addr = SlotAW'(base_q + SlotAW'(front));

  pmq_slot_mem #(
    .TOTAL_SLOTS (TOTAL_SLOTS)
  ) u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (slot_wr_en),
    .wr_addr_i (slot_wr_addr),
    .wr_data_i (wdata_q),
    .rd_en_i   (slot_rd_en),
    .rd_addr_i (slot_rd_addr),
    .rd_data_o (slot_rd_data)
  );

  // Output register
  logic                        out_valid_q;
  logic [pmq_pkg::StatW-1:0]   out_status_q;
  logic [pmq_pkg::DataW-1:0]   out_data_q;
  logic                        out_free;
  logic                        out_load;
  pmq_pkg::pmq_status_e        out_status_d;
  logic [pmq_pkg::DataW-1:0]   out_data_d;

  assign out_free = !out_valid_q || out_o.ready;

  // Sequence one operation: pointer read, check and write back, slot read
  always_comb begin
    state_d      = state_q;
    in_i.ready   = 1'b0;
    ptr_rd_en    = 1'b0;
    ptr_wr_en    = 1'b0;
    ptr_wr_data  = ptr_rd_data;
    slot_wr_en   = 1'b0;
    slot_rd_en   = 1'b0;
    out_load     = 1'b0;
    out_status_d = pmq_pkg::STAT_OK;
    out_data_d   = '0;
    case (state_q)
      pmq_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          ptr_rd_en = !in_badq;
          state_d   = pmq_pkg::ST_PTR;
        end
      end
      pmq_pkg::ST_PTR: begin
        if (badq_q) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = pmq_pkg::STAT_BADQ;
            state_d      = pmq_pkg::ST_IDLE;
          end
        end else if (func_q == pmq_pkg::FUNC_INSERT) begin
          if (out_free) begin
            out_load = 1'b1;
            state_d  = pmq_pkg::ST_IDLE;
            if (rear >= size_q) begin
              out_status_d = pmq_pkg::STAT_FULL;
            end else begin
              slot_wr_en  = 1'b1;
              ptr_wr_en   = 1'b1;
              ptr_wr_data = {front, OffW'(rear + OffW'(1))};
            end
          end
        end else if (front == rear) begin
          if (out_free) begin
            out_load     = 1'b1;
            out_status_d = pmq_pkg::STAT_EMPTY;
            state_d      = pmq_pkg::ST_IDLE;
          end
        end else begin
          slot_rd_en  = 1'b1;
          ptr_wr_en   = 1'b1;
          ptr_wr_data = {OffW'(front + OffW'(1)), rear};
          state_d     = pmq_pkg::ST_SLOT;
        end
      end
      pmq_pkg::ST_SLOT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_data_d = slot_rd_data;
          state_d    = pmq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pmq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Load a new result or drop the one taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_d;
      out_data_q   <= out_data_d;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_status_q;
  assign out_o.read_data = out_data_q;

endmodule
